@@ rtl/core/axi_lite_responder_bridge_assert.svh @@
// ----------------------------------------------------------------------------
// AXI-Lite responder bridge assertion macros
// Shared concurrent assertion forms used by the bridge checker.
// ----------------------------------------------------------------------------
`ifndef AXI_LITE_RESPONDER_BRIDGE_ASSERT_SVH
`define AXI_LITE_RESPONDER_BRIDGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ALRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ALRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/alrb_pkg.sv @@
// ----------------------------------------------------------------------------
// AXI-Lite responder bridge package
// Sizing constants, phase codes and the write strobe helpers.
// ----------------------------------------------------------------------------
package alrb_pkg;

  localparam int DATA_BYTES = 8;
  localparam int ADDR_BITS  = 32;

  // Addresses keep at most 32 significant bits.
  localparam int AddrKeep = (ADDR_BITS >= 32) ? 32 : ADDR_BITS;
  localparam logic [31:0] AddrMask = 32'((64'd1 << AddrKeep) - 64'd1);

  // All DATA_BYTES low strobe bits set.
  localparam logic [7:0] FullStrobe = 8'((16'd1 << DATA_BYTES) - 16'd1);
  localparam logic [3:0] FullBytes  = 4'(DATA_BYTES);

  localparam int NumStrobes = 15;
  typedef logic [7:0] strobe_t;
  localparam strobe_t AllowedStrobes [NumStrobes] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h08, 8'h0c, 8'h0f, 8'h10,
    8'h20, 8'h30, 8'h40, 8'h80, 8'hc0, 8'hf0, 8'hff
  };

  // Read and write machine phase codes.
  localparam logic       RD_ADDR = 1'b0;
  localparam logic       RD_DATA = 1'b1;
  localparam logic [1:0] WR_ADDR = 2'd0;
  localparam logic [1:0] WR_DATA = 2'd1;
  localparam logic [1:0] WR_RESP = 2'd2;
  localparam logic [1:0] WR_IDLE = 2'd3;

  function automatic logic strobe_allowed(input strobe_t s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumStrobes; i++) begin
      if (AllowedStrobes[i] == s) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [3:0] strobe_count(input strobe_t s);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'd0, s[i]};
    end
    return cnt;
  endfunction

  // Index of the lowest set strobe bit, 7 when none below bit 7 is set.
  function automatic logic [2:0] strobe_low(input strobe_t s);
    logic [2:0] low;
    low = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (s[i]) low = 3'(i);
    end
    return low;
  endfunction

endpackage

@@ rtl/core/axi_lite_responder_bridge.sv @@
// ----------------------------------------------------------------------------
// AXI-Lite responder bridge
// Plays the responder side of an AXI-Lite link, one sampled bus tick per beat.
// ----------------------------------------------------------------------------
// Each input beat carries the manager's AXI-Lite signals for one bus clock,
// and each beat produces exactly one result beat with the registered
// responder signals (arready, rvalid, rdata, awready, wready, bvalid) and any
// backing store request issued in that tick. All of a beat's work is short
// logic from the machine state registers into the result register, so a new
// beat is taken in every cycle unless a waiting result is stalled. The result
// register is the only buffer, so in_stall is raised only while a result
// waits and the output side stalls. A full strobe writes the whole bus word,
// a listed partial strobe packs the chosen bytes down to bit zero, and any
// other strobe drops the store while the write response still completes.
module axi_lite_responder_bridge
  import alrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_read_addr_valid,
  input  logic [31:0] in_read_addr,
  input  logic        in_read_data_ready,
  input  logic        in_write_addr_valid,
  input  logic [31:0] in_write_addr,
  input  logic        in_write_data_valid,
  input  logic [63:0] in_write_data,
  input  logic [7:0]  in_write_strobe,
  input  logic        in_write_resp_ready,
  input  logic [63:0] in_fetched_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_read_addr_ready,
  output logic        out_read_data_valid,
  output logic [63:0] out_read_data,
  output logic        out_write_addr_ready,
  output logic        out_write_data_ready,
  output logic        out_write_resp_valid,
  output logic        out_fetch_request,
  output logic [31:0] out_fetch_addr,
  output logic        out_store_request,
  output logic [31:0] out_store_addr,
  output logic [63:0] out_store_data,
  output logic [3:0]  out_store_bytes
);

  // Machine state. The bus flags double as the flag fields of the result,
  // since they only change when a beat is taken.
  logic        read_phase_r,  read_phase_nxt;
  logic [1:0]  write_phase_r, write_phase_nxt;
  logic [31:0] held_addr_r,   held_addr_nxt;
  logic        arready_r,     arready_nxt;
  logic        rvalid_r,      rvalid_nxt;
  logic [63:0] rdata_r,       rdata_nxt;
  logic        awready_r,     awready_nxt;
  logic        wready_r,      wready_nxt;
  logic        bvalid_r,      bvalid_nxt;

  // Per-beat request fields of the result register.
  logic        out_valid_r;
  logic        fetch_req_r,   fetch_req_nxt;
  logic [31:0] fetch_addr_r,  fetch_addr_nxt;
  logic        store_req_r,   store_req_nxt;
  logic [31:0] store_addr_r,  store_addr_nxt;
  logic [63:0] store_data_r,  store_data_nxt;
  logic [3:0]  store_bytes_r, store_bytes_nxt;

  logic        in_accept;
  logic [3:0]  strb_cnt;
  logic [2:0]  strb_low;
  logic [63:0] byte_mask;

  // A waiting result blocks the input only when it cannot leave this cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Byte packing for partial strobes: count and lowest lane.
  assign strb_cnt  = strobe_count(in_write_strobe);
  assign strb_low  = strobe_low(in_write_strobe);
  assign byte_mask = (strb_cnt >= 4'd8) ? '1
                   : ((64'd1 << {strb_cnt[2:0], 3'b000}) - 64'd1);

  always_comb begin
    read_phase_nxt  = read_phase_r;
    write_phase_nxt = write_phase_r;
    held_addr_nxt   = held_addr_r;
    arready_nxt     = arready_r;
    rvalid_nxt      = rvalid_r;
    rdata_nxt       = rdata_r;
    awready_nxt     = awready_r;
    wready_nxt      = wready_r;
    bvalid_nxt      = bvalid_r;
    fetch_req_nxt   = 1'b0;
    fetch_addr_nxt  = '0;
    store_req_nxt   = 1'b0;
    store_addr_nxt  = '0;
    store_data_nxt  = '0;
    store_bytes_nxt = '0;

    // Read machine: arready, then a fetch on the address handshake, then
    // rvalid until the manager takes the data.
    case (read_phase_r)
      RD_ADDR: begin
        arready_nxt = 1'b1;
        if (arready_r && in_read_addr_valid) begin
          arready_nxt    = 1'b0;
          fetch_req_nxt  = 1'b1;
          fetch_addr_nxt = in_read_addr & AddrMask;
          rdata_nxt      = in_fetched_word;
          read_phase_nxt = RD_DATA;
        end
      end
      RD_DATA: begin
        rvalid_nxt = 1'b1;
        if (rvalid_r && in_read_data_ready) begin
          rvalid_nxt     = 1'b0;
          read_phase_nxt = RD_ADDR;
        end
      end
      default: begin
        read_phase_nxt = RD_ADDR;
      end
    endcase

    // Write machine: address, data with the store, then the response.
    case (write_phase_r)
      WR_ADDR: begin
        awready_nxt = 1'b1;
        if (awready_r && in_write_addr_valid) begin
          awready_nxt     = 1'b0;
          held_addr_nxt   = in_write_addr & AddrMask;
          write_phase_nxt = WR_DATA;
        end
      end
      WR_DATA: begin
        wready_nxt = 1'b1;
        if (wready_r && in_write_data_valid) begin
          wready_nxt = 1'b0;
          if (strobe_allowed(in_write_strobe)) begin
            store_req_nxt  = 1'b1;
            store_addr_nxt = held_addr_r;
            if (in_write_strobe == FullStrobe) begin
              store_data_nxt  = in_write_data;
              store_bytes_nxt = FullBytes;
            end else begin
              store_data_nxt  = (in_write_data >> {strb_low, 3'b000}) & byte_mask;
              store_bytes_nxt = strb_cnt;
            end
          end
          write_phase_nxt = WR_RESP;
        end
      end
      WR_RESP: begin
        bvalid_nxt = 1'b1;
        if (bvalid_r && in_write_resp_ready) begin
          bvalid_nxt      = 1'b0;
          write_phase_nxt = WR_ADDR;
        end
      end
      WR_IDLE: begin
        // The unused phase falls back to the address phase, flags untouched.
        write_phase_nxt = WR_ADDR;
      end
      default: begin
        write_phase_nxt = WR_ADDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_phase_r  <= RD_ADDR;
      write_phase_r <= WR_ADDR;
      held_addr_r   <= '0;
      arready_r     <= 1'b0;
      rvalid_r      <= 1'b0;
      rdata_r       <= '0;
      awready_r     <= 1'b0;
      wready_r      <= 1'b0;
      bvalid_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        read_phase_r  <= read_phase_nxt;
        write_phase_r <= write_phase_nxt;
        held_addr_r   <= held_addr_nxt;
        arready_r     <= arready_nxt;
        rvalid_r      <= rvalid_nxt;
        rdata_r       <= rdata_nxt;
        awready_r     <= awready_nxt;
        wready_r      <= wready_nxt;
        bvalid_r      <= bvalid_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // Request fields carry no reset; they are qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fetch_req_r   <= fetch_req_nxt;
      fetch_addr_r  <= fetch_addr_nxt;
      store_req_r   <= store_req_nxt;
      store_addr_r  <= store_addr_nxt;
      store_data_r  <= store_data_nxt;
      store_bytes_r <= store_bytes_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_addr_ready  = arready_r;
  assign out_read_data_valid  = rvalid_r;
  assign out_read_data        = rdata_r;
  assign out_write_addr_ready = awready_r;
  assign out_write_data_ready = wready_r;
  assign out_write_resp_valid = bvalid_r;
  assign out_fetch_request    = fetch_req_r;
  assign out_fetch_addr       = fetch_addr_r;
  assign out_store_request    = store_req_r;
  assign out_store_addr       = store_addr_r;
  assign out_store_data       = store_data_r;
  assign out_store_bytes      = store_bytes_r;

endmodule

@@ rtl/core/alrb_checker.sv @@
// ----------------------------------------------------------------------------
// AXI-Lite responder bridge checker
// Port-level assertions on the bridge, attached to the bridge module by bind.
// ----------------------------------------------------------------------------
`include "axi_lite_responder_bridge_assert.svh"

module alrb_checker
  import alrb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_read_addr_ready,
  input logic        out_read_data_valid,
  input logic        out_write_data_ready,
  input logic        out_write_resp_valid,
  input logic        out_fetch_request,
  input logic [31:0] out_fetch_addr,
  input logic        out_store_request,
  input logic [3:0]  out_store_bytes
);

  // A stalled result stays offered with the same fetch and store request flags and fetch address.
  `ALRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_fetch_request) && $stable(out_store_request) && $stable(out_fetch_addr), "stalled result changed")

  // The input is held off only behind a waiting result.
  `ALRB_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a waiting result")

  // A fetch ends the address phase before rvalid is raised.
  `ALRB_ASSERT_IMPL(a_fetch_phase, clk, rst_n, out_valid && out_fetch_request, !out_read_addr_ready && !out_read_data_valid, "fetch outside the read address handshake")

  // A store ends the data phase and writes between one and a full word of bytes.
  `ALRB_ASSERT_IMPL(a_store_shape, clk, rst_n, out_valid && out_store_request, !out_write_data_ready && !out_write_resp_valid && (out_store_bytes != 4'd0) && (out_store_bytes <= FullBytes), "malformed store")

  // Without a fetch the fetch address reads as zero.
  `ALRB_ASSERT_IMPL(a_fetch_idle, clk, rst_n, out_valid && !out_fetch_request, out_fetch_addr == 32'd0, "fetch address without a fetch")

endmodule

bind axi_lite_responder_bridge alrb_checker u_alrb_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_read_addr_ready  (out_read_addr_ready),
  .out_read_data_valid  (out_read_data_valid),
  .out_write_data_ready (out_write_data_ready),
  .out_write_resp_valid (out_write_resp_valid),
  .out_fetch_request    (out_fetch_request),
  .out_fetch_addr       (out_fetch_addr),
  .out_store_request    (out_store_request),
  .out_store_bytes      (out_store_bytes)
);

@@ tb/sv/axi_lite_responder_bridge_test.sv @@
// ----------------------------------------------------------------------------
// AXI-Lite responder bridge testbench
// Drives sampled manager bus ticks into the bridge and checks every result
// beat against a cycle-level predictor of the read and write machines.
// ----------------------------------------------------------------------------
// The stimulus is planned ahead of time by a small manager model that runs
// its own copy of the predictor. It holds arvalid, awvalid and wvalid until
// the responder would take them, so most beats form well-formed transactions
// with random addresses, data and strobes. Noise segments toggle every
// signal at random. A short directed opening covers the address and data
// extremes, a full strobe, a partial strobe and an unlisted strobe.
module axi_lite_responder_bridge_test;
  import alrb_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 9;
  localparam int DIRECTED_TICKS   = 24;
  localparam int RANDOM_TICKS     = 2000;
  localparam int TAIL_BEATS       = 150;
  localparam int LONG_HOLD_AT     = 600;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES     = 8;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam int REPORT_LIMIT     = 10;

  // Corner values used by the directed opening.
  localparam logic [31:0] EdgeAddrs [4] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001
  };
  localparam logic [63:0] EdgeWords [4] = '{
    64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0001
  };
  // Full strobe, top byte only, a pattern outside the list, upper half.
  localparam logic [7:0] EdgeStrobes [4] = '{8'hff, 8'h80, 8'h55, 8'hf0};

  typedef enum int {STYLE_DIRECTED, STYLE_CLEAN, STYLE_NOISE} stim_style_e;

  // One sampled clock of the manager's signals.
  typedef struct packed {
    logic        ar_valid;
    logic [31:0] ar_addr;
    logic        r_ready;
    logic        aw_valid;
    logic [31:0] aw_addr;
    logic        w_valid;
    logic [63:0] w_data;
    logic [7:0]  w_strb;
    logic        b_ready;
    logic [63:0] fetched;
    logic        pause_before;
  } bus_tick_t;

  // The responder's registered signals and store requests after one tick.
  typedef struct packed {
    logic        arready;
    logic        rvalid;
    logic [63:0] rdata;
    logic        awready;
    logic        wready;
    logic        bvalid;
    logic        fetch_req;
    logic [31:0] fetch_addr;
    logic        store_req;
    logic [31:0] store_addr;
    logic [63:0] store_data;
    logic [3:0]  store_bytes;
  } resp_tick_t;

  typedef struct packed {
    logic        rd_phase;
    logic [1:0]  wr_phase;
    logic [31:0] held_addr;
    logic        arready;
    logic        rvalid;
    logic [63:0] rdata;
    logic        awready;
    logic        wready;
    logic        bvalid;
  } bridge_state_t;

  // Manager intentions that must stay asserted until they are taken.
  typedef struct packed {
    bit          ar_on;
    logic [31:0] ar_addr;
    bit          aw_on;
    logic [31:0] aw_addr;
    bit          w_on;
    logic [63:0] w_data;
    logic [7:0]  w_strb;
  } manager_t;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid      = 1'b0;
  logic      in_beat_taken = 1'b0;
  logic      out_stall     = 1'b0;
  logic      long_hold_on  = 1'b0;
  bus_tick_t drive_tick    = '0;

  logic        in_stall;
  logic        out_valid;
  logic        out_read_addr_ready;
  logic        out_read_data_valid;
  logic [63:0] out_read_data;
  logic        out_write_addr_ready;
  logic        out_write_data_ready;
  logic        out_write_resp_valid;
  logic        out_fetch_request;
  logic [31:0] out_fetch_addr;
  logic        out_store_request;
  logic [31:0] out_store_addr;
  logic [63:0] out_store_data;
  logic [3:0]  out_store_bytes;

  bus_tick_t     planned_ticks[$];
  resp_tick_t    predicted_responses[$];
  bridge_state_t responder_model = '0;
  bridge_state_t plan_state;
  manager_t      mgr;

  int total_planned;
  int beats_in;
  int beats_out;
  int mismatches;
  int fetches_seen;
  int stores_seen;
  int dropped_writes;
  int stall_seen;
  int send_gap;
  int stall_left;
  int hold_left;
  bit hold_done;
  int ar_pick;
  int aw_pick;
  int w_pick;

  axi_lite_responder_bridge u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_read_addr_valid   (drive_tick.ar_valid),
    .in_read_addr         (drive_tick.ar_addr),
    .in_read_data_ready   (drive_tick.r_ready),
    .in_write_addr_valid  (drive_tick.aw_valid),
    .in_write_addr        (drive_tick.aw_addr),
    .in_write_data_valid  (drive_tick.w_valid),
    .in_write_data        (drive_tick.w_data),
    .in_write_strobe      (drive_tick.w_strb),
    .in_write_resp_ready  (drive_tick.b_ready),
    .in_fetched_word      (drive_tick.fetched),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_read_addr_ready  (out_read_addr_ready),
    .out_read_data_valid  (out_read_data_valid),
    .out_read_data        (out_read_data),
    .out_write_addr_ready (out_write_addr_ready),
    .out_write_data_ready (out_write_data_ready),
    .out_write_resp_valid (out_write_resp_valid),
    .out_fetch_request    (out_fetch_request),
    .out_fetch_addr       (out_fetch_addr),
    .out_store_request    (out_store_request),
    .out_store_addr       (out_store_addr),
    .out_store_data       (out_store_data),
    .out_store_bytes      (out_store_bytes)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Advances the responder by one bus tick. A handshake is judged against the
  // ready or valid flag the responder drove during the tick, and the flag is
  // raised again on every tick that does not complete a handshake.
  function automatic resp_tick_t advance_responder(inout bridge_state_t s,
                                                   input bus_tick_t t);
    resp_tick_t  r;
    bit          listed;
    int          n_bytes;
    int          low_byte;
    logic [63:0] keep;
    r = '0;
    if (s.rd_phase == RD_ADDR) begin
      if (s.arready && t.ar_valid) begin
        s.arready    = 1'b0;
        r.fetch_req  = 1'b1;
        r.fetch_addr = t.ar_addr & AddrMask;
        s.rdata      = t.fetched;
        s.rd_phase   = RD_DATA;
      end else begin
        s.arready = 1'b1;
      end
    end else begin
      if (s.rvalid && t.r_ready) begin
        s.rvalid   = 1'b0;
        s.rd_phase = RD_ADDR;
      end else begin
        s.rvalid = 1'b1;
      end
    end

    case (s.wr_phase)
      WR_ADDR: begin
        if (s.awready && t.aw_valid) begin
          s.awready   = 1'b0;
          s.held_addr = t.aw_addr & AddrMask;
          s.wr_phase  = WR_DATA;
        end else begin
          s.awready = 1'b1;
        end
      end
      WR_DATA: begin
        if (s.wready && t.w_valid) begin
          s.wready = 1'b0;
          listed   = 1'b0;
          for (int i = 0; i < NumStrobes; i++) begin
            if (AllowedStrobes[i] == t.w_strb) listed = 1'b1;
          end
          // Strobes outside the list drop the store but still get a response.
          if (listed) begin
            r.store_req  = 1'b1;
            r.store_addr = s.held_addr;
            if (t.w_strb == FullStrobe) begin
              r.store_data  = t.w_data;
              r.store_bytes = FullBytes;
            end else begin
              n_bytes  = $countones(t.w_strb);
              low_byte = 0;
              while (low_byte < 7 && !t.w_strb[low_byte]) low_byte++;
              keep = (n_bytes >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n_bytes)) - 64'd1);
              r.store_data  = (t.w_data >> (8 * low_byte)) & keep;
              r.store_bytes = 4'(n_bytes);
            end
          end
          s.wr_phase = WR_RESP;
        end else begin
          s.wready = 1'b1;
        end
      end
      WR_RESP: begin
        if (s.bvalid && t.b_ready) begin
          s.bvalid   = 1'b0;
          s.wr_phase = WR_ADDR;
        end else begin
          s.bvalid = 1'b1;
        end
      end
      default: begin
        // The idle code is never entered from reset; it only falls back.
        s.wr_phase = WR_ADDR;
      end
    endcase

    r.arready = s.arready;
    r.rvalid  = s.rvalid;
    r.rdata   = s.rdata;
    r.awready = s.awready;
    r.wready  = s.wready;
    r.bvalid  = s.bvalid;
    return r;
  endfunction

  // Random values lean on the all-zero and all-one corners now and then.
  function automatic logic [31:0] any_addr();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  function automatic logic [63:0] any_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 64'h0000_0000_0000_0000;
    if (pick == 1) return 64'hffff_ffff_ffff_ffff;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] any_strobe();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 8'h00;
    if (pick < 12) return AllowedStrobes[$urandom_range(0, NumStrobes - 1)];
    return 8'($urandom);
  endfunction

  // Plans a run of bus ticks. In the directed and clean styles the manager
  // holds each valid with a stable payload until the planning copy of the
  // responder shows it taken; the noise style ignores all protocol rules.
  task automatic plan_ticks(input stim_style_e style, input int count,
                            input bit pause_first);
    bus_tick_t     t;
    bridge_state_t prior;
    bit            directed;
    directed = (style == STYLE_DIRECTED);
    for (int i = 0; i < count; i++) begin
      t = '0;
      if (style == STYLE_NOISE) begin
        t.ar_valid = 1'($urandom);
        t.ar_addr  = any_addr();
        t.r_ready  = 1'($urandom);
        t.aw_valid = 1'($urandom);
        t.aw_addr  = any_addr();
        t.w_valid  = 1'($urandom);
        t.w_data   = any_word();
        t.w_strb   = 8'($urandom);
        t.b_ready  = 1'($urandom);
      end else begin
        if (!mgr.ar_on && (directed || $urandom_range(0, 3) != 0)) begin
          mgr.ar_on   = 1'b1;
          mgr.ar_addr = directed ? EdgeAddrs[ar_pick % 4] : any_addr();
          ar_pick++;
        end
        if (!mgr.aw_on && (directed || $urandom_range(0, 3) != 0)) begin
          mgr.aw_on   = 1'b1;
          mgr.aw_addr = directed ? EdgeAddrs[(aw_pick + 1) % 4] : any_addr();
          aw_pick++;
        end
        if (!mgr.w_on && (directed || $urandom_range(0, 3) != 0)) begin
          mgr.w_on   = 1'b1;
          mgr.w_data = directed ? EdgeWords[(w_pick + 1) % 4] : any_word();
          mgr.w_strb = directed ? EdgeStrobes[w_pick % 4] : any_strobe();
          w_pick++;
        end
        t.ar_valid = mgr.ar_on;
        t.ar_addr  = mgr.ar_on ? mgr.ar_addr : any_addr();
        t.aw_valid = mgr.aw_on;
        t.aw_addr  = mgr.aw_on ? mgr.aw_addr : any_addr();
        t.w_valid  = mgr.w_on;
        t.w_data   = mgr.w_on ? mgr.w_data : any_word();
        t.w_strb   = mgr.w_on ? mgr.w_strb : any_strobe();
        t.r_ready  = directed || ($urandom_range(0, 3) != 0);
        t.b_ready  = directed || ($urandom_range(0, 3) != 0);
      end
      t.fetched      = directed ? EdgeWords[i % 4] : any_word();
      t.pause_before = pause_first && (i == 0);

      prior = plan_state;
      void'(advance_responder(plan_state, t));
      if (prior.rd_phase == RD_ADDR && plan_state.rd_phase == RD_DATA) mgr.ar_on = 1'b0;
      if (prior.wr_phase == WR_ADDR && plan_state.wr_phase == WR_DATA) mgr.aw_on = 1'b0;
      if (prior.wr_phase == WR_DATA && plan_state.wr_phase == WR_RESP) mgr.w_on = 1'b0;
      planned_ticks.push_back(t);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("Mismatch on result beat %0d, %s: expected %h, actual %h",
                 beats_out, name, want, got);
    end
  endtask

  // Sender. A beat stays on the inputs until it is taken; between beats the
  // sender may pause for a random burst. A beat marked to pause waits until
  // every predicted response has come back. Near the end of the run and
  // during the long receiver hold-off there are no gaps, so the bridge's
  // single result register fills and in_stall has to rise.
  always @(negedge clk) begin
    bit next_valid;
    next_valid = in_valid && !in_beat_taken;
    if (rst_n && !next_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (planned_ticks.size() > 0 &&
                   !(planned_ticks[0].pause_before && predicted_responses.size() > 0)) begin
        drive_tick <= planned_ticks.pop_front();
        next_valid = 1'b1;
        if (planned_ticks.size() >= TAIL_BEATS && !long_hold_on &&
            $urandom_range(0, 19) == 0)
          send_gap = $urandom_range(1, 15);
      end
    end
    in_valid <= next_valid;
  end

  // Receiver. Random stall bursts, one long hold-off once enough beats have
  // gone in, and no stalls at all over the final beats.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && beats_in >= LONG_HOLD_AT) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (beats_in + TAIL_BEATS < total_planned && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 15);
    end
    out_stall    <= (hold_left > 0) || (stall_left > 0);
    long_hold_on <= (hold_left > 0);
  end

  // Monitor. Every accepted input beat advances the predictor and queues one
  // predicted response; every accepted result beat is checked against the
  // oldest one. Sampling happens at the rising edge, before the bridge's
  // registers update.
  always @(posedge clk) begin
    resp_tick_t want;
    resp_tick_t got;
    bit         was_data;
    in_beat_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && in_stall) stall_seen++;
      if (in_valid && !in_stall) begin
        was_data = (responder_model.wr_phase == WR_DATA);
        want = advance_responder(responder_model, drive_tick);
        if (was_data && responder_model.wr_phase == WR_RESP && !want.store_req)
          dropped_writes++;
        predicted_responses.push_back(want);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        got.arready     = out_read_addr_ready;
        got.rvalid      = out_read_data_valid;
        got.rdata       = out_read_data;
        got.awready     = out_write_addr_ready;
        got.wready      = out_write_data_ready;
        got.bvalid      = out_write_resp_valid;
        got.fetch_req   = out_fetch_request;
        got.fetch_addr  = out_fetch_addr;
        got.store_req   = out_store_request;
        got.store_addr  = out_store_addr;
        got.store_data  = out_store_data;
        got.store_bytes = out_store_bytes;
        if (predicted_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Result beat %0d arrived with no response predicted", beats_out);
        end else begin
          want = predicted_responses.pop_front();
          check_field("arready", 64'(want.arready), 64'(got.arready));
          check_field("rvalid", 64'(want.rvalid), 64'(got.rvalid));
          check_field("rdata", want.rdata, got.rdata);
          check_field("awready", 64'(want.awready), 64'(got.awready));
          check_field("wready", 64'(want.wready), 64'(got.wready));
          check_field("bvalid", 64'(want.bvalid), 64'(got.bvalid));
          check_field("fetch_request", 64'(want.fetch_req), 64'(got.fetch_req));
          check_field("fetch_addr", 64'(want.fetch_addr), 64'(got.fetch_addr));
          check_field("store_request", 64'(want.store_req), 64'(got.store_req));
          check_field("store_addr", 64'(want.store_addr), 64'(got.store_addr));
          check_field("store_data", want.store_data, got.store_data);
          check_field("store_bytes", 64'(want.store_bytes), 64'(got.store_bytes));
          if (want.fetch_req) fetches_seen++;
          if (want.store_req) stores_seen++;
        end
        beats_out++;
      end
    end
  end

  // Plans the whole run, releases reset, then waits for the last response
  // and for a quiet drain in which no stray result beat may appear.
  initial begin : run_control
    int planned;
    int seg;
    plan_state = '0;
    mgr        = '0;
    plan_ticks(STYLE_DIRECTED, DIRECTED_TICKS, 1'b0);
    planned = 0;
    while (planned < RANDOM_TICKS) begin
      seg = $urandom_range(20, 150);
      plan_ticks(($urandom_range(0, 4) == 0) ? STYLE_NOISE : STYLE_CLEAN, seg,
                 planned == 0 || $urandom_range(0, 5) == 0);
      planned += seg;
    end
    total_planned = planned_ticks.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (planned_ticks.size() > 0 || in_valid || predicted_responses.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d bus ticks: %0d reads fetched, %0d stores, %0d writes dropped",
             beats_out, fetches_seen, stores_seen, dropped_writes);
    $display("Input held back on %0d cycles; %0d field mismatches",
             stall_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d responses outstanding", predicted_responses.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/alrb_pkg.sv
rtl/core/axi_lite_responder_bridge.sv
rtl/core/alrb_checker.sv
tb/sv/axi_lite_responder_bridge_test.sv
